/* rtl/rbnh_pkg.sv */
`default_nettype none
package rbnh_pkg;
  // configuration register indexes
  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X   = 3'd3;
  localparam logic [2:0] REG_DIR_Y   = 3'd4;
  localparam logic [2:0] REG_DIR_Z   = 3'd5;
  localparam int CFG_IDX_W = 3;
endpackage
`default_nettype wire

/* rtl/rbnh_div.sv */
`default_nettype none
// unsigned restoring divider, one quotient bit a cycle
module rbnh_div #(
  parameter int NW = 34,
  parameter int QW = 50
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [NW-1:0] den,
  output logic               done,
  output logic [QW-1:0]      quo
);
  localparam int CW = $clog2(QW + 1);
  logic [NW:0]     rem;
  logic [NW-1:0]   dsr;
  logic [QW-1:0]   nsh;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [NW:0]     trial;

  always_comb begin
    trial = {rem[NW-1:0], nsh[QW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dsr  <= den;
        nsh  <= QW'(num) << (QW - NW);
        quo  <= '0;
        cnt  <= CW'(QW);
      end else if (busy) begin
        nsh <= nsh << 1;
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[QW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/rbnh_front.sv */
`default_nettype none
// forms slab offsets per axis, two-entry queue towards the back part
module rbnh_front #(
  parameter int CW = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [3*CW-1:0]  ctr,
  input  wire logic [3*CW-4:0]  half,
  input  wire logic             last_in,
  input  wire logic [3*CW-1:0]  start,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output logic [6*(CW+2)-1:0]   q_off,
  output logic                  q_last
);
  localparam int OW = CW + 2;
  localparam int EW = 6 * OW + 1;
  logic [EW-1:0] mem [2];
  logic [1:0]    cnt;
  logic          wp, rp;
  logic [EW-1:0] ent;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ent[(2*a)*OW +: OW] = OW'($signed(ctr[a*CW +: CW]))
        - OW'(half[a*(CW-1) +: CW-1]) - OW'($signed(start[a*CW +: CW]));
      ent[(2*a+1)*OW +: OW] = OW'($signed(ctr[a*CW +: CW]))
        + OW'(half[a*(CW-1) +: CW-1]) - OW'($signed(start[a*CW +: CW]));
    end
    ent[EW-1] = last_in;
  end

  assign full    = cnt == 2'd2;
  assign q_valid = cnt != 2'd0;
  assign q_off   = mem[rp][EW-2:0];
  assign q_last  = mem[rp][EW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push && !full) begin
        mem[wp] <= ent;
        wp <= ~wp;
      end
      if (q_pop && q_valid) rp <= ~rp;
      cnt <= cnt + {1'b0, push && !full} - {1'b0, q_pop && q_valid};
    end
  end
endmodule
`default_nettype wire

/* rtl/rbnh_back.sv */
`default_nettype none
// per-axis slab times on two shared dividers, entry/exit, running nearest
module rbnh_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic [6*(CW+2)-1:0] q_off,
  input  wire logic              q_last,
  input  wire logic [3*CW-1:0]   dir,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   box_hit,
  output logic [CW-1:0]          box_time,
  output logic                   best_hit,
  output logic [CW-1:0]          best_time,
  output logic                   set_done
);
  localparam int OW = CW + 2;
  localparam int QW = OW + FB;
  localparam int TW = CW + 2;
  localparam logic signed [TW-1:0] TMAX = TW'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [TW-1:0] TMIN = -TMAX - 1;

  typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_AXIS, S_FIN, S_OUT} st_t;
  st_t st;
  logic [1:0] axis;
  logic signed [OW-1:0] lo, hi;
  logic signed [CW-1:0] d;
  logic signed [TW-1:0] entry, exitm, t0, t1, tl, th, tres;
  logic miss, dv0, dv1, last_r;
  logic [QW-1:0] q0, q1;
  logic signed [CW-1:0] ntime;
  logic nvalid;
  logic [OW-1:0] ulo, uhi, ud;

  assign lo = q_off[(2*axis)*OW +: OW];
  assign hi = q_off[(2*axis+1)*OW +: OW];
  assign d  = dir[axis*CW +: CW];
  assign ulo = lo[OW-1] ? -lo : lo;
  assign uhi = hi[OW-1] ? -hi : hi;
  assign ud  = d[CW-1] ? -OW'(d) : OW'(d);

  rbnh_div #(.NW(OW), .QW(QW)) u_div0 (
    .clk(clk), .rst(rst), .start(st == S_START), .num(ulo), .den(ud),
    .done(dv0), .quo(q0));
  rbnh_div #(.NW(OW), .QW(QW)) u_div1 (
    .clk(clk), .rst(rst), .start(st == S_START), .num(uhi), .den(ud),
    .done(dv1), .quo(q1));

  function automatic logic signed [TW-1:0] sat(input logic [QW-1:0] q,
                                               input logic neg);
    logic [QW-1:0] cap;
    logic [QW-1:0] m;
    begin
      cap = neg ? QW'(TMAX) + 1'b1 : QW'(TMAX);
      m = q > cap ? cap : q;
      sat = neg ? -TW'(m) : TW'(m);
    end
  endfunction

  always_comb begin
    t0 = sat(q0, lo[OW-1] != d[CW-1]);
    t1 = sat(q1, hi[OW-1] != d[CW-1]);
    tl = t0 < t1 ? t0 : t1;
    th = t0 < t1 ? t1 : t0;
    tres = (miss || exitm < entry) ? TMAX : (entry < TMIN ? TMIN : entry);
  end

  assign q_pop = st == S_FIN;
  assign empty = st != S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      ntime  <= CW'(TMAX);
      nvalid <= 1'b0;
      axis   <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (q_valid) begin
            axis  <= '0;
            entry <= TMIN - 1;
            exitm <= TMAX + 1;
            miss  <= 1'b0;
            st    <= S_AXIS;
          end
        end
        S_AXIS: begin
          if (d == '0) begin
            if (lo > 0 || hi < 0) miss <= 1'b1;
            if (axis == 2'd2) st <= S_FIN;
            else axis <= axis + 1'b1;
          end else begin
            st <= S_START;
          end
        end
        S_START: st <= S_WAIT;
        S_WAIT: begin
          if (dv0 && dv1) begin
            if (tl > entry) entry <= tl;
            if (th < exitm) exitm <= th;
            if (axis == 2'd2) st <= S_FIN;
            else begin
              axis <= axis + 1'b1;
              st   <= S_AXIS;
            end
          end
        end
        S_FIN: begin
          box_hit  <= !(miss || exitm < entry);
          box_time <= CW'(tres);
          set_done <= q_last;
          last_r   <= q_last;
          if (!(miss || exitm < entry)) begin
            best_hit  <= 1'b1;
            best_time <= (!nvalid || tres < TW'(ntime)) ? CW'(tres) : ntime;
            ntime     <= (!nvalid || tres < TW'(ntime)) ? CW'(tres) : ntime;
            nvalid    <= 1'b1;
          end else begin
            best_hit  <= nvalid;
            best_time <= ntime;
          end
          st <= S_OUT;
        end
        S_OUT: begin
          if (last_r) begin
            ntime  <= CW'(TMAX);
            nvalid <= 1'b0;
            last_r <= 1'b0;
          end
          if (pop) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/ray_box_nearest_hit.sv */
`default_nettype none
// channel  | direction | handshake        | payload
// box in   | input     | push / full      | center_*, half_*, last_box
// result   | output    | empty / pop      | box_hit, box_time, best_*, set_done
// config   | input     | cfg_valid/ready  | cfg_index, cfg_data
// a request's run time, at Q16.16 as at other widths, is set by
//   the radix-2 divider pair that handles one axis (both slab times) at a time
// an axis with zero direction skips the dividers
// synchronous reset clears the ray to zero and the running nearest hit
// the front queue holds two boxes while the back part is busy or stalled
module ray_box_nearest_hit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [COORD_WIDTH-1:0]       center_x,
  input  wire logic [COORD_WIDTH-1:0]       center_y,
  input  wire logic [COORD_WIDTH-1:0]       center_z,
  input  wire logic [COORD_WIDTH-2:0]       half_x,
  input  wire logic [COORD_WIDTH-2:0]       half_y,
  input  wire logic [COORD_WIDTH-2:0]       half_z,
  input  wire logic                         last_box,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              box_hit,
  output logic [COORD_WIDTH-1:0]            box_time,
  output logic                              best_hit,
  output logic [COORD_WIDTH-1:0]            best_time,
  output logic                              set_done,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rbnh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]       cfg_data
);
  import rbnh_pkg::*;
  localparam int CW = COORD_WIDTH;

  logic [CW-1:0] start_x, start_y, start_z, dir_x, dir_y, dir_z;
  logic          q_valid, q_pop, q_last;
  logic [6*(CW+2)-1:0] q_off;

  assign cfg_ready = 1'b1;

  // ray registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0; start_y <= '0; start_z <= '0;
      dir_x   <= '0; dir_y   <= '0; dir_z   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        REG_START_Z: start_z <= cfg_data;
        REG_DIR_X:   dir_x   <= cfg_data;
        REG_DIR_Y:   dir_y   <= cfg_data;
        REG_DIR_Z:   dir_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  rbnh_front #(.CW(CW)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .ctr({center_z, center_y, center_x}),
    .half({half_z, half_y, half_x}),
    .last_in(last_box),
    .start({start_z, start_y, start_x}),
    .q_valid(q_valid), .q_pop(q_pop), .q_off(q_off), .q_last(q_last));

  rbnh_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop),
    .q_off(q_off), .q_last(q_last),
    .dir({dir_z, dir_y, dir_x}),
    .empty(empty), .pop(pop),
    .box_hit(box_hit), .box_time(box_time), .best_hit(best_hit),
    .best_time(best_time), .set_done(set_done));
endmodule
`default_nettype wire
